// ===== src/tlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page table walk unit: memory
// geometry, entry layout, opcodes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tlpt_pkg;

   // Memory geometry: frame count is a power of two, 4096 frames
   localparam int FRAME_BITS        = 12;
   localparam int FRAME_COUNT       = 1 << FRAME_BITS;
   localparam int ENTRIES_PER_TABLE = 32;
   localparam int SLOT_BITS         = $clog2(ENTRIES_PER_TABLE);
   localparam int MEM_WORDS         = FRAME_COUNT * ENTRIES_PER_TABLE;
   localparam int ADDR_BITS         = $clog2(MEM_WORDS);

   // Field widths
   localparam int OPCODE_WIDTH = 2;
   localparam int VA_WIDTH     = 16;
   localparam int INDEX_WIDTH  = 17;
   localparam int WORD_WIDTH   = 16;
   localparam int PA_WIDTH     = 18;
   localparam int CFG_WIDTH    = 12;
   localparam int OFFSET_BITS  = 6;

   // Entry layout
   localparam int PRESENT_BIT     = 0;
   localparam int DIRTY_BIT       = 1;
   localparam int ENTRY_FRAME_LSB = 4;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_WALK_READ  = 2'd0,
      OP_WALK_WRITE = 2'd1,
      OP_STORE      = 2'd2,
      OP_LOAD       = 2'd3
   } opcode_type;

   // Memory address source
   typedef enum logic [1:0] {
      ADDR_REQ_DIR  = 2'd0,  // directory slot from the incoming request
      ADDR_REQ_WORD = 2'd1,  // word index from the incoming request
      ADDR_TABLE    = 2'd2,  // table slot from the directory entry just read
      ADDR_DIRTY    = 2'd3   // held table entry address, for the dirty write-back
   } addr_sel_type;

   // Response value source
   typedef enum logic [1:0] {
      RSP_ZERO  = 2'd0,
      RSP_FAULT = 2'd1,
      RSP_PHYS  = 2'd2,
      RSP_WORD  = 2'd3
   } rsp_sel_type;

   typedef struct packed {
      logic         accept;
      logic         mem_rd;
      logic         mem_wr;
      addr_sel_type addr_sel;
      logic         rsp_load;
      rsp_sel_type  rsp_sel;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       entry_present;
   } status_type;

endpackage

// ===== src/tlpt_datapath.sv =====
// ----------------------------------------------------------------------------
// tlpt_datapath
// Request registers, directory frame register, the physical word memory with
// its registered read port, and the response register.
// ----------------------------------------------------------------------------
module tlpt_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [tlpt_pkg::CFG_WIDTH-1:0]        csr_write_data,
   input  logic [tlpt_pkg::OPCODE_WIDTH-1:0]     req_opcode,
   input  logic [tlpt_pkg::VA_WIDTH-1:0]         req_virtual_address,
   input  logic [tlpt_pkg::INDEX_WIDTH-1:0]      req_word_index,
   input  logic [tlpt_pkg::WORD_WIDTH-1:0]       req_word_data,
   input  tlpt_pkg::cmd_type                     cmd,
   output tlpt_pkg::status_type                  status,
   output logic [tlpt_pkg::PA_WIDTH-1:0]         rsp_physical_address,
   output logic                                  rsp_fault,
   output logic [tlpt_pkg::WORD_WIDTH-1:0]       rsp_word_out
);

   logic [tlpt_pkg::WORD_WIDTH-1:0] mem [tlpt_pkg::MEM_WORDS];

   logic [tlpt_pkg::FRAME_BITS-1:0] dir_frame_ff;
   tlpt_pkg::opcode_type            op_ff;
   logic [tlpt_pkg::VA_WIDTH-1:0]   va_ff;
   logic [tlpt_pkg::ADDR_BITS-1:0]  tbl_addr_ff, tbl_addr_in;
   logic [tlpt_pkg::WORD_WIDTH-1:0] rd_data_ff;
   logic [tlpt_pkg::ADDR_BITS-1:0]  mem_addr;
   logic [tlpt_pkg::WORD_WIDTH-1:0] mem_wdata;
   logic [tlpt_pkg::FRAME_BITS-1:0] entry_frame;

   logic [tlpt_pkg::PA_WIDTH-1:0]   pa_ff, pa_in;
   logic                            fault_ff, fault_in;
   logic [tlpt_pkg::WORD_WIDTH-1:0] word_ff, word_in;

   assign entry_frame = rd_data_ff[tlpt_pkg::ENTRY_FRAME_LSB +: tlpt_pkg::FRAME_BITS];
   assign tbl_addr_in = {entry_frame, va_ff[tlpt_pkg::OFFSET_BITS +: tlpt_pkg::SLOT_BITS]};

   always_comb begin
      mem_wdata = req_word_data;
      unique case (cmd.addr_sel)
         tlpt_pkg::ADDR_REQ_DIR: begin
            mem_addr = {dir_frame_ff,
                        req_virtual_address[tlpt_pkg::VA_WIDTH-1 -: tlpt_pkg::SLOT_BITS]};
         end
         tlpt_pkg::ADDR_REQ_WORD: begin
            mem_addr = req_word_index[tlpt_pkg::ADDR_BITS-1:0];
         end
         tlpt_pkg::ADDR_TABLE: begin
            mem_addr = tbl_addr_in;
         end
         default: begin
            mem_addr  = tbl_addr_ff;
            mem_wdata = rd_data_ff;
            mem_wdata[tlpt_pkg::DIRTY_BIT] = 1'b1;
         end
      endcase
   end

   // Single port: one read or one write a cycle, read data registered
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_frame_ff <= '0;
      end else if (csr_write_enable) begin
         dir_frame_ff <= csr_write_data[tlpt_pkg::FRAME_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= tlpt_pkg::opcode_type'(req_opcode);
         va_ff <= req_virtual_address;
      end
      if (cmd.mem_rd && cmd.addr_sel == tlpt_pkg::ADDR_TABLE) begin
         tbl_addr_ff <= tbl_addr_in;
      end
   end

   always_comb begin
      pa_in    = '0;
      fault_in = 1'b0;
      word_in  = '0;
      case (cmd.rsp_sel)
         tlpt_pkg::RSP_FAULT: fault_in = 1'b1;
         tlpt_pkg::RSP_PHYS:  pa_in = tlpt_pkg::PA_WIDTH'({entry_frame,
                                       va_ff[tlpt_pkg::OFFSET_BITS-1:0]});
         tlpt_pkg::RSP_WORD:  word_in = rd_data_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         pa_ff    <= pa_in;
         fault_ff <= fault_in;
         word_ff  <= word_in;
      end
   end

   assign status.op            = op_ff;
   assign status.entry_present = rd_data_ff[tlpt_pkg::PRESENT_BIT];

   assign rsp_physical_address = pa_ff;
   assign rsp_fault            = fault_ff;
   assign rsp_word_out         = word_ff;

endmodule

// ===== src/tlpt_controller.sv =====
// ----------------------------------------------------------------------------
// tlpt_controller
// Walk sequencer: accepts a request, steps through the directory and table
// reads, issues the dirty write-back and owns the response valid flag.
// ----------------------------------------------------------------------------
module tlpt_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tlpt_pkg::OPCODE_WIDTH-1:0] req_opcode,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tlpt_pkg::cmd_type                 cmd,
   input  tlpt_pkg::status_type              status
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DIR   = 5'b00010,
      S_TBL   = 5'b00100,
      S_LOAD  = 5'b01000,
      S_STORE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Response register may take a new result when empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.addr_sel = tlpt_pkg::ADDR_REQ_DIR;
      cmd.rsp_sel  = tlpt_pkg::RSP_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (tlpt_pkg::opcode_type'(req_opcode))
                  tlpt_pkg::OP_STORE: begin
                     cmd.mem_wr   = 1'b1;
                     cmd.addr_sel = tlpt_pkg::ADDR_REQ_WORD;
                     state_in     = S_STORE;
                  end
                  tlpt_pkg::OP_LOAD: begin
                     cmd.mem_rd   = 1'b1;
                     cmd.addr_sel = tlpt_pkg::ADDR_REQ_WORD;
                     state_in     = S_LOAD;
                  end
                  default: begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_DIR;
                  end
               endcase
            end
         end
         S_DIR: begin
            if (status.entry_present) begin
               cmd.mem_rd   = 1'b1;
               cmd.addr_sel = tlpt_pkg::ADDR_TABLE;
               state_in     = S_TBL;
            end else if (out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = tlpt_pkg::RSP_FAULT;
               state_in     = S_IDLE;
            end
         end
         S_TBL: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
               if (!status.entry_present) begin
                  cmd.rsp_sel = tlpt_pkg::RSP_FAULT;
               end else begin
                  cmd.rsp_sel = tlpt_pkg::RSP_PHYS;
                  // mark the page dirty on a write translation
                  if (status.op == tlpt_pkg::OP_WALK_WRITE) begin
                     cmd.mem_wr   = 1'b1;
                     cmd.addr_sel = tlpt_pkg::ADDR_DIRTY;
                  end
               end
            end
         end
         S_LOAD: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = tlpt_pkg::RSP_WORD;
               state_in     = S_IDLE;
            end
         end
         S_STORE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_rd && cmd.mem_wr))
      else $error("memory read and write issued in the same cycle");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register loaded while holding an untaken result");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new request accepted right after a transfer");

   a_dirty_only_on_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_wr && cmd.addr_sel == tlpt_pkg::ADDR_DIRTY) |->
         (status.op == tlpt_pkg::OP_WALK_WRITE && status.entry_present &&
          cmd.rsp_sel == tlpt_pkg::RSP_PHYS))
      else $error("dirty write-back outside a successful write translation");
`endif

endmodule

// ===== src/two_level_page_table_walk_unit.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_walk_unit
// Two-level page table walker over a single-port memory of 16-bit words.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A translation issues the directory read
// when the request transfers, the table read in S_DIR, and loads its result in
// S_TBL; the dirty write-back of a write translation goes out with the result.
// A failed directory lookup loads its result in S_DIR, a store in S_STORE and a
// load in S_LOAD. The steps are set by the single memory port with registered
// read data: the two table reads depend on each other. A result waits in an
// output register, and a new request is taken as soon as the walk ends, even
// while that result is still waiting; a walk that reaches its result while the
// previous one is still untaken holds in its last step until that result
// transfers. The word memory powers up undefined and has no clearing pass:
// tables must be stored before they are walked.
// ----------------------------------------------------------------------------
module two_level_page_table_walk_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [tlpt_pkg::CFG_WIDTH-1:0]    csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tlpt_pkg::OPCODE_WIDTH-1:0] req_opcode,
   input  logic [tlpt_pkg::VA_WIDTH-1:0]     req_virtual_address,
   input  logic [tlpt_pkg::INDEX_WIDTH-1:0]  req_word_index,
   input  logic [tlpt_pkg::WORD_WIDTH-1:0]   req_word_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tlpt_pkg::PA_WIDTH-1:0]     rsp_physical_address,
   output logic                              rsp_fault,
   output logic [tlpt_pkg::WORD_WIDTH-1:0]   rsp_word_out
);

   tlpt_pkg::cmd_type    cmd;
   tlpt_pkg::status_type status;

   tlpt_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   tlpt_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_opcode           (req_opcode),
      .req_virtual_address  (req_virtual_address),
      .req_word_index       (req_word_index),
      .req_word_data        (req_word_data),
      .cmd                  (cmd),
      .status               (status),
      .rsp_physical_address (rsp_physical_address),
      .rsp_fault            (rsp_fault),
      .rsp_word_out         (rsp_word_out)
   );

endmodule

// ===== test/tb_two_level_page_table_walk_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_level_page_table_walk_unit
// Self-checking bench for the page table walker. Tables are built with store
// transfers and walked with read and write translations. Loads read words
// back. A shadow copy of the word memory tracks every store and dirty-bit
// update and predicts each response. Directed walks come first, then three
// random phases, each with its own directory frame and handshake pressure.
// ----------------------------------------------------------------------------
module tb_two_level_page_table_walk_unit;

   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 3000;
   localparam int POOL_SIZE     = 6;

   typedef logic [tlpt_pkg::VA_WIDTH-1:0]    va_type;
   typedef logic [tlpt_pkg::INDEX_WIDTH-1:0] index_type;
   typedef logic [tlpt_pkg::WORD_WIDTH-1:0]  word_type;
   typedef logic [tlpt_pkg::FRAME_BITS-1:0]  frame_type;
   typedef logic [tlpt_pkg::CFG_WIDTH-1:0]   cfg_type;
   typedef logic [tlpt_pkg::ADDR_BITS-1:0]   addr_type;

   typedef struct packed {
      logic [tlpt_pkg::PA_WIDTH-1:0]   physical_address;
      logic                            fault;
      logic [tlpt_pkg::WORD_WIDTH-1:0] word_out;
   } walk_response_type;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              csr_write_enable = 1'b0;
   cfg_type                           csr_write_data = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [tlpt_pkg::OPCODE_WIDTH-1:0] req_opcode = tlpt_pkg::OP_WALK_READ;
   va_type                            req_virtual_address = '0;
   index_type                         req_word_index = '0;
   word_type                          req_word_data = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [tlpt_pkg::PA_WIDTH-1:0]     rsp_physical_address;
   logic                              rsp_fault;
   word_type                          rsp_word_out;

   // Shadow of the word memory; only written words exist in it
   word_type               table_words [int];
   int                     written_words [$];
   cfg_type                dir_frame_shadow = '0;
   frame_type              frame_pool [POOL_SIZE];
   walk_response_type      awaited_responses [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   two_level_page_table_walk_unit uut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_virtual_address  (req_virtual_address),
      .req_word_index       (req_word_index),
      .req_word_data        (req_word_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_physical_address (rsp_physical_address),
      .rsp_fault            (rsp_fault),
      .rsp_word_out         (rsp_word_out)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Expected response of one transfer; applies stores and dirty bits to the shadow
   function automatic walk_response_type walk_outcome(input tlpt_pkg::opcode_type op,
                                                      input va_type va,
                                                      input index_type widx,
                                                      input word_type wdata);
      walk_response_type rsp;
      addr_type          dpos;
      addr_type          tpos;
      word_type          dent;
      word_type          tent;
      rsp = '0;
      case (op)
         tlpt_pkg::OP_STORE: begin
            if (!table_words.exists(widx)) written_words.push_back(int'(widx));
            table_words[widx] = wdata;
         end
         tlpt_pkg::OP_LOAD: begin
            rsp.word_out = table_words[widx];
         end
         default: begin
            dpos = {dir_frame_shadow, va[15:11]};
            dent = table_words[dpos];
            if (!dent[tlpt_pkg::PRESENT_BIT]) begin
               rsp.fault = 1'b1;
            end else begin
               tpos = {dent[15:tlpt_pkg::ENTRY_FRAME_LSB], va[10:6]};
               tent = table_words[tpos];
               if (!tent[tlpt_pkg::PRESENT_BIT]) begin
                  rsp.fault = 1'b1;
               end else begin
                  rsp.physical_address = {tent[15:tlpt_pkg::ENTRY_FRAME_LSB],
                                          va[tlpt_pkg::OFFSET_BITS-1:0]};
                  if (op == tlpt_pkg::OP_WALK_WRITE) begin
                     tent[tlpt_pkg::DIRTY_BIT] = 1'b1;
                     table_words[tpos] = tent;
                  end
               end
            end
         end
      endcase
      return rsp;
   endfunction

   function automatic word_type make_entry(input frame_type frame, input logic present);
      return {frame, 3'($urandom), present};
   endfunction

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // Valid stays high after a transfer until the next gap or drain drops it
   task automatic send_item(input tlpt_pkg::opcode_type op, input va_type va,
                            input index_type widx, input word_type wdata);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_virtual_address <= va;
      req_word_index      <= widx;
      req_word_data       <= wdata;
      do @(posedge clock); while (!req_ready);
      awaited_responses.push_back(walk_outcome(op, va, widx, wdata));
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_directory_frame(input cfg_type frame);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= frame;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dir_frame_shadow = frame;
   endtask

   task automatic store_if_unwritten(input index_type widx, input word_type wdata);
      if (!table_words.exists(widx))
         send_item(tlpt_pkg::OP_STORE, va_type'($urandom), widx, wdata);
   endtask

   // Full-range walks: directory slot 0 maps to frame 4095, top table slot gives max address
   task automatic test_mapped_walks();
      write_directory_frame('0);
      send_item(tlpt_pkg::OP_STORE, va_type'($urandom), 17'd0, 16'hFFF1);
      send_item(tlpt_pkg::OP_STORE, va_type'($urandom), {12'hFFF, 5'd0}, 16'h1231);
      send_item(tlpt_pkg::OP_WALK_READ, 16'h003F, index_type'($urandom),
                word_type'($urandom));
      send_item(tlpt_pkg::OP_WALK_WRITE, 16'h0000, index_type'($urandom),
                word_type'($urandom));
      send_item(tlpt_pkg::OP_LOAD, va_type'($urandom), {12'hFFF, 5'd0},
                word_type'($urandom));
      send_item(tlpt_pkg::OP_STORE, va_type'($urandom), {12'hFFF, 5'd31}, 16'hFFFF);
      send_item(tlpt_pkg::OP_WALK_WRITE, 16'h07FF, index_type'($urandom),
                word_type'($urandom));
      send_item(tlpt_pkg::OP_WALK_READ, 16'h07C0, index_type'($urandom),
                word_type'($urandom));
   endtask

   // Absent directory entry, then absent table entry, and a load of that table entry after the failed write
   task automatic test_missing_entries();
      send_item(tlpt_pkg::OP_STORE, va_type'($urandom), 17'd31, 16'hFFF0);
      send_item(tlpt_pkg::OP_WALK_READ, 16'hFFFF, index_type'($urandom),
                word_type'($urandom));
      send_item(tlpt_pkg::OP_WALK_WRITE, 16'hF800, index_type'($urandom),
                word_type'($urandom));
      send_item(tlpt_pkg::OP_STORE, va_type'($urandom), 17'd1, 16'h0021);
      send_item(tlpt_pkg::OP_STORE, va_type'($urandom), 17'd95, 16'hFFFE);
      send_item(tlpt_pkg::OP_WALK_WRITE, {5'd1, 5'd31, 6'd5}, index_type'($urandom),
                word_type'($urandom));
      send_item(tlpt_pkg::OP_WALK_READ, {5'd1, 5'd31, 6'd0}, index_type'($urandom),
                word_type'($urandom));
      send_item(tlpt_pkg::OP_LOAD, va_type'($urandom), 17'd95, word_type'($urandom));
   endtask

   task automatic test_word_access();
      send_item(tlpt_pkg::OP_STORE, va_type'($urandom), 17'h1FFFF, 16'h0000);
      send_item(tlpt_pkg::OP_LOAD, va_type'($urandom), 17'h1FFFF, word_type'($urandom));
      send_item(tlpt_pkg::OP_STORE, va_type'($urandom), 17'h10000, 16'hA5A5);
      send_item(tlpt_pkg::OP_LOAD, va_type'($urandom), 17'h10000, word_type'($urandom));
      send_item(tlpt_pkg::OP_STORE, va_type'($urandom), 17'h0AAAA, 16'h5A5A);
      send_item(tlpt_pkg::OP_LOAD, va_type'($urandom), 17'h0AAAA, word_type'($urandom));
   endtask

   // Build entries on demand so the walk never reads an unwritten word
   task automatic walk_sequence();
      va_type                 va;
      addr_type               dpos;
      addr_type               tpos;
      word_type               dent;
      tlpt_pkg::opcode_type   op;
      va   = va_type'($urandom);
      op   = $urandom_range(1) ? tlpt_pkg::OP_WALK_WRITE : tlpt_pkg::OP_WALK_READ;
      dpos = {dir_frame_shadow, va[15:11]};
      if (!table_words.exists(dpos) || $urandom_range(9) == 0)
         send_item(tlpt_pkg::OP_STORE, va_type'($urandom), dpos,
                   make_entry(frame_pool[$urandom_range(POOL_SIZE-1)],
                              $urandom_range(99) < 88));
      dent = table_words[dpos];
      if (dent[tlpt_pkg::PRESENT_BIT]) begin
         tpos = {dent[15:tlpt_pkg::ENTRY_FRAME_LSB], va[10:6]};
         // never rewrite the directory entry that this walk goes through
         if (!table_words.exists(tpos) || ($urandom_range(9) == 0 && tpos != dpos))
            send_item(tlpt_pkg::OP_STORE, va_type'($urandom), tpos,
                      make_entry(frame_type'($urandom), $urandom_range(99) < 85));
      end
      send_item(op, va, index_type'($urandom), word_type'($urandom));
   endtask

   task automatic test_random_walks(input cfg_type dir_frame, input int count);
      int                     stop_at;
      int                     pick;
      bit                     paused;
      index_type              widx;
      write_directory_frame(dir_frame);
      foreach (frame_pool[i]) frame_pool[i] = frame_type'($urandom);
      stop_at = items_sent + count;
      paused  = 1'b0;
      while (items_sent < stop_at) begin
         // hold the sender once until the walker is empty
         if (!paused && items_sent >= stop_at - count / 2) begin
            drain_results();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 60) begin
            walk_sequence();
         end else if (pick < 78) begin
            send_item(tlpt_pkg::OP_LOAD, va_type'($urandom),
                      index_type'(written_words[$urandom_range(written_words.size() - 1)]),
                      word_type'($urandom));
         end else if (pick < 90) begin
            send_item(tlpt_pkg::OP_STORE, va_type'($urandom), index_type'($urandom),
                      word_type'($urandom));
         end else begin
            widx = index_type'($urandom);
            store_if_unwritten(widx, word_type'($urandom));
            send_item(tlpt_pkg::OP_LOAD, va_type'($urandom), widx, word_type'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_responses
      walk_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            flag_error($sformatf("response with none expected: pa=%h fault=%b word=%h",
                                 rsp_physical_address, rsp_fault, rsp_word_out));
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_physical_address !== want.physical_address)
               flag_error($sformatf("physical_address expected %h got %h",
                                    want.physical_address, rsp_physical_address));
            if (rsp_fault !== want.fault)
               flag_error($sformatf("fault expected %b got %b", want.fault, rsp_fault));
            if (rsp_word_out !== want.word_out)
               flag_error($sformatf("word_out expected %h got %h", want.word_out, rsp_word_out));
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      send_idle_pct = 34;
      recv_idle_pct = 78;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_mapped_walks();
      test_missing_entries();
      test_word_access();
      test_random_walks(cfg_type'($urandom), 360);
      send_idle_pct = 78;
      recv_idle_pct = 34;
      test_random_walks(12'hFFF, 360);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_walks(cfg_type'($urandom), 360);
      drain_results();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tlpt_pkg.sv
src/tlpt_datapath.sv
src/tlpt_controller.sv
src/two_level_page_table_walk_unit.sv
test/tb_two_level_page_table_walk_unit.sv
